### rtl/core/bfba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared constants of the best-fit bin assigner: register indexes, status
// codes, register widths and register reset values.
// ----------------------------------------------------------------------------
package bfba_pkg;

   // Configuration port shape.
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;
   localparam int LIMIT_W    = 10;

   localparam logic [CSR_ADDR_W-1:0] REG_BIN_SIZE   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_FREE   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_BIN_LIMIT  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_LIMIT_MODE = 2'd3;

   localparam logic [CSR_DATA_W-1:0] BIN_SIZE_RESET = 24'd4096;
   localparam logic [CSR_DATA_W-1:0] MIN_FREE_RESET = 24'd1;
   localparam logic [LIMIT_W-1:0]    BIN_LIMIT_RESET = 10'd0;

   // Result status codes.
   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LIMIT     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED   = 2'd3;

   // Result side-band: status in the low bits, then the new-bin flag.
   localparam int RSP_USER_W = STATUS_W + 1;

endpackage

### rtl/core/bfba_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfba_table
// Free-space table storage: one write port and one read port with a
// registered read result. Each entry holds a free space and a bin number.
// ----------------------------------------------------------------------------
module bfba_table #(
   parameter int TABLE_DEPTH = 64,
   parameter int SIZE_BITS   = 24,
   parameter int BIN_BITS    = 16
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  logic [SIZE_BITS-1:0]           wr_free,
   input  logic [BIN_BITS-1:0]            wr_bin,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output logic [SIZE_BITS-1:0]           rd_free,
   output logic [BIN_BITS-1:0]            rd_bin
);

   typedef struct packed {
      logic [SIZE_BITS-1:0] free;
      logic [BIN_BITS-1:0]  bin;
   } entry_type;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= '{free: wr_free, bin: wr_bin};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_free = rd_data_ff.free;
   assign rd_bin  = rd_data_ff.bin;

endmodule

### rtl/core/best_fit_bin_assigner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_bin_assigner
// Online best-fit bin packing: one item size in, one assigned bin out.
// ----------------------------------------------------------------------------
// Each request item carries a size; the block answers with one response item
// naming the bin that takes it. A table of up to TABLE_DEPTH partly filled
// bins is kept sorted by free space (ties oldest first). The first bin with
// enough room is taken, removed, and its reduced space re-inserted; if none
// fits, a new bin is numbered from the running counter and left with bin_size
// minus (size modulo bin_size) free, or none if that remainder is zero. Space
// below min_free, or beyond a full table, is not kept. One item is handled at
// a time, and all size, space and limit arithmetic and compares go through a
// single shared subtractor under a small sequencer. Each entry scanned,
// shifted down on removal or shifted up on insertion costs one table read and
// one compare or write; a new bin also needs a bit-serial remainder. The table
// needs no clearing after reset: a fill count marks the valid entries. The
// request side is ready again as soon as the result sits in the response
// register.
// ----------------------------------------------------------------------------
module best_fit_bin_assigner #(
   parameter int TABLE_DEPTH = 64,
   parameter int SIZE_BITS   = 24,
   parameter int BIN_BITS    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SIZE_BITS+7)/8)*8-1:0]       req_tdata,   // item_size
   // Response channel.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((BIN_BITS+7)/8)*8-1:0]        rsp_tdata,   // bin_number
   output logic [bfba_pkg::RSP_USER_W-1:0]      rsp_tuser,   // status, opened_new
   // Configuration write port.
   input  logic                                 csr_we,
   input  logic [bfba_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [bfba_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import bfba_pkg::*;

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CntW = $clog2(TABLE_DEPTH + 1);
   localparam int BitW = $clog2(SIZE_BITS);
   localparam int RspDataW = ((BIN_BITS + 7) / 8) * 8;
   // The shared subtractor must hold a shifted remainder, a register value,
   // a bin number and the bin count limit.
   localparam int W0   = (SIZE_BITS + 1 > CSR_DATA_W) ? SIZE_BITS + 1 : CSR_DATA_W;
   localparam int W1   = (BIN_BITS > LIMIT_W) ? BIN_BITS : LIMIT_W;
   localparam int AluW = (W0 > W1) ? W0 : W1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_REM_RD,
      S_REM_WR,
      S_NOFIT,
      S_DIV,
      S_SUB,
      S_KEEP,
      S_INS_RD,
      S_INS_CMP,
      S_INS_LOW,
      S_FINISH
   } state_type;

   // Configuration registers.
   logic [SIZE_BITS-1:0]  bin_size_ff;
   logic [CSR_DATA_W-1:0] min_free_ff;
   logic [LIMIT_W-1:0]    limit_ff;
   logic                  mode_ff;

   // Sequencer and working registers.
   state_type            state_ff, state_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [SIZE_BITS-1:0] space_ff, space_in;
   logic [BIN_BITS-1:0]  bin_ff, bin_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 opened_ff, opened_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic [BitW-1:0]      bit_ff, bit_in;
   logic [BIN_BITS-1:0]  next_bin_ff, next_bin_in;

   // Response register.
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [BIN_BITS-1:0]  rsp_bin_ff, rsp_bin_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                 rsp_opened_ff, rsp_opened_in;

   // Shared subtract and compare unit.
   logic [AluW-1:0] alu_a, alu_b;
   logic [AluW:0]   alu_diff;
   logic            alu_ge;

   // Table ports.
   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [SIZE_BITS-1:0] wr_free, rd_free;
   logic [BIN_BITS-1:0]  wr_bin, rd_bin;

   logic [AW-1:0]   idx_inc;
   logic [CntW-1:0] idx_ext_inc, idx_ext_inc2, cnt_m1;

   assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_ge   = ~alu_diff[AluW];

   assign idx_inc      = idx_ff + AW'(1);
   assign idx_ext_inc  = CntW'(idx_ff) + CntW'(1);
   assign idx_ext_inc2 = CntW'(idx_ff) + CntW'(2);
   assign cnt_m1       = count_ff - CntW'(1);

   bfba_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .SIZE_BITS   (SIZE_BITS),
      .BIN_BITS    (BIN_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_free (wr_free),
      .wr_bin  (wr_bin),
      .rd_addr (rd_addr),
      .rd_free (rd_free),
      .rd_bin  (rd_bin)
   );

   always_comb begin
      state_in      = state_ff;
      size_in       = size_ff;
      space_in      = space_ff;
      bin_in        = bin_ff;
      status_in     = status_ff;
      opened_in     = opened_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      bit_in        = bit_ff;
      next_bin_in   = next_bin_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_bin_in    = rsp_bin_ff;
      rsp_status_in = rsp_status_ff;
      rsp_opened_in = rsp_opened_ff;
      alu_a         = '0;
      alu_b         = '0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_free       = space_ff;
      wr_bin        = bin_ff;
      rd_addr       = idx_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               size_in   = req_tdata[SIZE_BITS-1:0];
               status_in = STATUS_OK;
               opened_in = 1'b0;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            // The limit is broken when next_bin is above it.
            alu_a = AluW'(limit_ff);
            alu_b = AluW'(next_bin_ff);
            if (mode_ff && (limit_ff != '0) && !alu_ge) begin
               bin_in    = '0;
               status_in = STATUS_LIMIT;
               state_in  = S_FINISH;
            end else if (count_ff == '0) begin
               state_in = S_NOFIT;
            end else begin
               idx_in   = '0;
               state_in = S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            alu_a = AluW'(rd_free);
            alu_b = AluW'(size_ff);
            if (alu_ge) begin
               bin_in   = rd_bin;
               space_in = alu_diff[SIZE_BITS-1:0];
               if (idx_ext_inc < count_ff) begin
                  state_in = S_REM_RD;
               end else begin
                  count_in = cnt_m1;
                  state_in = S_KEEP;
               end
            end else if (idx_ext_inc == count_ff) begin
               state_in = S_NOFIT;
            end else begin
               idx_in   = idx_inc;
               state_in = S_SRCH_RD;
            end
         end
         S_REM_RD: begin
            rd_addr  = idx_inc;
            state_in = S_REM_WR;
         end
         S_REM_WR: begin
            wr_en   = 1'b1;
            wr_free = rd_free;
            wr_bin  = rd_bin;
            if (idx_ext_inc2 == count_ff) begin
               count_in = cnt_m1;
               state_in = S_KEEP;
            end else begin
               idx_in   = idx_inc;
               state_in = S_REM_RD;
            end
         end
         S_NOFIT: begin
            if (next_bin_ff == '0) begin
               bin_in    = '0;
               status_in = STATUS_EXHAUSTED;
               state_in  = S_FINISH;
            end else begin
               bin_in      = next_bin_ff;
               next_bin_in = next_bin_ff + BIN_BITS'(1);
               opened_in   = 1'b1;
               space_in    = '0;
               bit_in      = BitW'(SIZE_BITS - 1);
               state_in    = (bin_size_ff == '0) ? S_KEEP : S_DIV;
            end
         end
         S_DIV: begin
            // Restoring remainder, one size bit per cycle, MSB first.
            alu_a    = AluW'({space_ff, size_ff[bit_ff]});
            alu_b    = AluW'(bin_size_ff);
            space_in = alu_ge ? alu_diff[SIZE_BITS-1:0] : alu_a[SIZE_BITS-1:0];
            if (bit_ff == '0) begin
               state_in = S_SUB;
            end else begin
               bit_in = bit_ff - BitW'(1);
            end
         end
         S_SUB: begin
            alu_a = AluW'(bin_size_ff);
            alu_b = AluW'(space_ff);
            if (space_ff != '0) begin
               space_in = alu_diff[SIZE_BITS-1:0];
            end
            state_in = S_KEEP;
         end
         S_KEEP: begin
            alu_a = AluW'(space_ff);
            alu_b = AluW'(min_free_ff);
            if (!alu_ge) begin
               state_in = S_FINISH;
            end else if (count_ff == CntW'(TABLE_DEPTH)) begin
               status_in = STATUS_DROPPED;
               state_in  = S_FINISH;
            end else if (count_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               count_in = count_ff + CntW'(1);
               state_in = S_FINISH;
            end else begin
               idx_in   = cnt_m1[AW-1:0];
               state_in = S_INS_RD;
            end
         end
         S_INS_RD: begin
            state_in = S_INS_CMP;
         end
         S_INS_CMP: begin
            // Walk down from the top: larger entries move up one slot, the
            // new entry lands just above the first one that is not larger.
            alu_a   = AluW'(space_ff);
            alu_b   = AluW'(rd_free);
            wr_en   = 1'b1;
            wr_addr = idx_inc;
            if (alu_ge) begin
               count_in = count_ff + CntW'(1);
               state_in = S_FINISH;
            end else begin
               wr_free = rd_free;
               wr_bin  = rd_bin;
               if (idx_ff == '0) begin
                  state_in = S_INS_LOW;
               end else begin
                  idx_in   = idx_ff - AW'(1);
                  state_in = S_INS_RD;
               end
            end
         end
         S_INS_LOW: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            count_in = count_ff + CntW'(1);
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_bin_in    = bin_ff;
               rsp_status_in = status_ff;
               rsp_opened_in = opened_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         next_bin_ff   <= BIN_BITS'(1);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         next_bin_ff   <= next_bin_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      size_ff       <= size_in;
      space_ff      <= space_in;
      bin_ff        <= bin_in;
      status_ff     <= status_in;
      opened_ff     <= opened_in;
      idx_ff        <= idx_in;
      bit_ff        <= bit_in;
      rsp_bin_ff    <= rsp_bin_in;
      rsp_status_ff <= rsp_status_in;
      rsp_opened_ff <= rsp_opened_in;
   end

   // Configuration registers take a write at any edge with the enable high and reset low.
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_size_ff <= SIZE_BITS'(BIN_SIZE_RESET);
         min_free_ff <= MIN_FREE_RESET;
         limit_ff    <= BIN_LIMIT_RESET;
         mode_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_BIN_SIZE:   bin_size_ff <= SIZE_BITS'(csr_wdata);
            REG_MIN_FREE:   min_free_ff <= csr_wdata;
            REG_BIN_LIMIT:  limit_ff    <= csr_wdata[LIMIT_W-1:0];
            REG_LIMIT_MODE: mode_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RspDataW'(rsp_bin_ff);
   assign rsp_tuser  = {rsp_opened_ff, rsp_status_ff};

endmodule

### rtl/core/bfba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfba_checker
// Port-level checks of the best-fit bin assigner, bound to its top level.
// ----------------------------------------------------------------------------
module bfba_checker #(
   parameter int BIN_BITS = 16
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [((BIN_BITS+7)/8)*8-1:0]   rsp_tdata,
   input logic [bfba_pkg::RSP_USER_W-1:0] rsp_tuser
);

   import bfba_pkg::*;

   logic [STATUS_W-1:0] status;
   logic                opened;

   assign status = rsp_tuser[STATUS_W-1:0];
   assign opened = rsp_tuser[STATUS_W];

   // A stalled response item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response item changed while stalled");

   // One item at a time: the request side drops ready after an accept.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while an item is in progress");

   // Errors report bin 0 and no new bin.
   a_error_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == STATUS_LIMIT || status == STATUS_EXHAUSTED)
      |-> rsp_tdata == '0 && !opened)
      else $error("error result with a bin number or new-bin flag");

   // Successful placements always name a real bin.
   a_ok_bin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == STATUS_OK || status == STATUS_DROPPED) |-> rsp_tdata != '0)
      else $error("placement reported with bin number 0");

   // Only a freshly opened bin can lose its free space to a full table.
   a_drop_new: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == STATUS_DROPPED |-> opened)
      else $error("free space dropped for a reused bin");

endmodule

bind best_fit_bin_assigner bfba_checker #(
   .BIN_BITS (BIN_BITS)
) u_bfba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### sim/best_fit_bin_assigner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_bin_assigner_tb
// Self-checking testbench for the best-fit bin assigner.
// ----------------------------------------------------------------------------
// Item sizes go in on the request stream. A behavioral copy of the bin table
// runs beside the block and predicts the bin, status and new-bin flag of every
// accepted item. Response items are checked in order against those
// predictions. Directed tests cover the size and register extremes, the limit
// check, zero bin size and zero item size. Random phases under several
// register settings follow, with bursts of idling on both streams. A long
// response hold-off fills the block.
// ----------------------------------------------------------------------------
module best_fit_bin_assigner_tb;
   import bfba_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int SIZE_BITS   = 24;
   localparam int BIN_BITS    = 16;

   // Far above the slowest legal run: about a thousand items, each at most the
   // worst-case item time, plus stalls and register writes.
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   // Slowest single item: full table scan, shifts and the serial remainder.
   localparam int DRAIN_CYCLES = 4 * TABLE_DEPTH + SIZE_BITS + 32;

   // Expected response of one item. The order matches the response ports:
   // bin number on tdata, then status and the new-bin flag on tuser.
   typedef struct packed {
      logic [BIN_BITS-1:0] bin_number;
      logic [STATUS_W-1:0] status;
      logic                opened_new;
   } placement_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata   = '0;   // item_size
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [15:0]           rsp_tdata;          // bin_number
   logic [RSP_USER_W-1:0] rsp_tuser;          // status, opened_new
   logic                  csr_we      = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   best_fit_bin_assigner #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .SIZE_BITS   (SIZE_BITS),
      .BIN_BITS    (BIN_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // --------------------------------------------------------------------------
   // Predicted bin table. Entries 0 .. fill-1 are valid and sorted by free
   // space, ascending, with equal spaces oldest first.
   // --------------------------------------------------------------------------
   logic [SIZE_BITS-1:0] fs_tab [TABLE_DEPTH];
   logic [BIN_BITS-1:0]  id_tab [TABLE_DEPTH];
   int                   fill         = 0;
   logic [BIN_BITS-1:0]  next_bin_num = 16'd1;

   // Register copies, starting at the reset values of the block.
   logic [23:0] cfg_bin_size   = BIN_SIZE_RESET;
   logic [23:0] cfg_min_free   = MIN_FREE_RESET;
   logic [9:0]  cfg_bin_limit  = BIN_LIMIT_RESET;
   logic        cfg_limit_mode = 1'b0;

   placement_type expected_placements [$];
   placement_type oldest;
   int unsigned   mismatches  = 0;
   int unsigned   cycle_count = 0;

   // Shared between the stimulus and the response-side process (stall_left is the latter's own).
   bit idle_on     = 1'b0;
   int hold_cycles = 0;
   int stall_left  = 0;

   // Places one item in the predicted table and returns what the block must
   // answer. The limit check comes before anything else, even for an item
   // that would fit an open bin.
   function automatic placement_type place_item(input logic [SIZE_BITS-1:0] size);
      placement_type        res;
      logic [SIZE_BITS-1:0] space;
      logic [SIZE_BITS-1:0] rem;
      int                   pos;
      int                   i;
      res.bin_number = '0;
      res.status     = STATUS_OK;
      res.opened_new = 1'b0;
      if (cfg_limit_mode && cfg_bin_limit != 0 && next_bin_num > cfg_bin_limit) begin
         res.status = STATUS_LIMIT;
         return res;
      end
      // Best fit: the table is sorted, so the first entry large enough wins.
      pos = fill;
      for (i = 0; i < fill && pos == fill; i++)
         if (fs_tab[i] >= size)
            pos = i;
      if (pos < fill) begin
         res.bin_number = id_tab[pos];
         space = fs_tab[pos] - size;
         for (i = pos; i < fill - 1; i++) begin
            fs_tab[i] = fs_tab[i + 1];
            id_tab[i] = id_tab[i + 1];
         end
         fill--;
      end else if (next_bin_num == 0) begin
         // The counter has wrapped: no bin can be opened any more.
         res.status = STATUS_EXHAUSTED;
         return res;
      end else begin
         res.bin_number = next_bin_num;
         res.opened_new = 1'b1;
         next_bin_num++;
         rem   = (cfg_bin_size == 0) ? '0 : size % cfg_bin_size;
         space = (rem == 0) ? '0 : cfg_bin_size - rem;
      end
      if (space >= cfg_min_free) begin
         if (fill >= TABLE_DEPTH) begin
            res.status = STATUS_DROPPED;
         end else begin
            // Insert after every entry with equal or smaller free space.
            pos = 0;
            while (pos < fill && fs_tab[pos] <= space)
               pos++;
            for (i = fill; i > pos; i--) begin
               fs_tab[i] = fs_tab[i - 1];
               id_tab[i] = id_tab[i - 1];
            end
            fs_tab[pos] = space;
            id_tab[pos] = res.bin_number;
            fill++;
         end
      end
      return res;
   endfunction

   // Random item size shaped around the bin size. Upper-half sizes rarely fit
   // an open bin, so a fill-heavy mix keeps opening bins until the table is
   // full; small sizes pack into open bins and exercise the best-fit search.
   function automatic logic [23:0] pick_size(input logic [23:0] bs, input bit fill_heavy);
      int unsigned b;
      int unsigned lo;
      int unsigned hi;
      int unsigned r;
      int unsigned v;
      b = (bs == 0) ? 1 : bs;
      if (fill_heavy && $urandom_range(0, 9) < 8)
         r = 7;
      else
         r = $urandom_range(0, 9);
      case (r)
         0: v = $urandom;
         1: begin
            case ($urandom_range(0, 4))
               0: v = 0;
               1: v = 1;
               2: v = b;
               3: v = b - 1;
               default: v = b + 1;
            endcase
         end
         2, 3, 4, 5: begin
            hi = (b / 4 < 1) ? 1 : b / 4;
            v  = $urandom_range(1, hi);
         end
         6, 7, 8: begin
            hi = (b < 2) ? 1 : b - 1;
            lo = (b / 2 + 1 > hi) ? hi : b / 2 + 1;
            v  = $urandom_range(lo, hi);
         end
         default: begin
            lo = (b + 1 > 24'hFFFFFF) ? 24'hFFFFFF : b + 1;
            hi = (4 * b > 24'hFFFFFF) ? 24'hFFFFFF : 4 * b;
            v  = $urandom_range(lo, hi);
         end
      endcase
      if (v > 24'hFFFFFF)
         v = v & 24'hFFFFFF;
      return v[23:0];
   endfunction

   // --------------------------------------------------------------------------
   // Clock, reset and the run limit.
   // --------------------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Response side. Ready changes only at the falling edge. A hold-off asked
   // for by a test is counted down here at each falling edge; random stalls
   // come only while idling is switched on.
   // --------------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left = stall_left - 1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 12);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Every accepted response item is compared with the oldest prediction.
   // Values are sampled at the rising edge, before the block updates them.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_placements.size() == 0) begin
            mismatches++;
            $display("%0t: no result expected, got bin %0d status %0d opened %0b",
                     $time, rsp_tdata, rsp_tuser[STATUS_W-1:0], rsp_tuser[STATUS_W]);
         end else begin
            oldest = expected_placements.pop_front();
            if (rsp_tdata !== oldest.bin_number) begin
               mismatches++;
               $display("%0t: bin_number expected %0d, got %0d",
                        $time, oldest.bin_number, rsp_tdata);
            end
            if (rsp_tuser[STATUS_W-1:0] !== oldest.status) begin
               mismatches++;
               $display("%0t: status expected %0d, got %0d",
                        $time, oldest.status, rsp_tuser[STATUS_W-1:0]);
            end
            if (rsp_tuser[STATUS_W] !== oldest.opened_new) begin
               mismatches++;
               $display("%0t: opened_new expected %0b, got %0b",
                        $time, oldest.opened_new, rsp_tuser[STATUS_W]);
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Request side.
   // --------------------------------------------------------------------------

   // Offers one item and records its prediction once the block takes it.
   // Valid is left high when no gap follows, so back-to-back items never
   // drop it; end_burst lowers it when a run of items is over.
   task automatic send_item(input logic [23:0] size);
      placement_type p;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= size;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      p = place_item(size);
      expected_placements.insert(expected_placements.size(), p);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
      end
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Stops offering items until every predicted result has come back.
   task automatic wait_drained();
      end_burst();
      while (expected_placements.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [23:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Registers are only rewritten with the block idle, so the predictor copies
   // can be updated at once.
   task automatic configure(input logic [23:0] bs, input logic [23:0] mf,
                            input logic [9:0] lim, input logic mode);
      wait_drained();
      write_reg(REG_BIN_SIZE, bs);
      write_reg(REG_MIN_FREE, mf);
      write_reg(REG_BIN_LIMIT, {14'd0, lim});
      write_reg(REG_LIMIT_MODE, {23'd0, mode});
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_bin_size   = bs;
      cfg_min_free   = mf;
      cfg_bin_limit  = lim;
      cfg_limit_mode = mode;
   endtask

   // --------------------------------------------------------------------------
   // Tests.
   // --------------------------------------------------------------------------

   // Reset settings: 4096-byte bins, free space of one byte or more kept.
   task automatic test_size_extremes();
      send_item(24'd1);          // new bin 1, 4095 left
      send_item(24'hFFFFFF);     // oversize: remainder 4095 leaves one byte
      send_item(24'd0);          // zero size takes the tightest bin
      send_item(24'd4096);       // exact multiple: nothing left to keep
      send_item(24'd8192);
      send_item(24'd5000);       // oversize with a remainder
      send_item(24'd4095);       // fills bin 1 exactly
      send_item(24'd3000);       // the first fits bin 5, the second opens a new bin
      send_item(24'd3000);
      send_item(24'd1000);
      send_item(24'h800000);
      send_item(24'h555555);
      send_item(24'hAAAAAA);
   endtask

   task automatic test_bin_size_corners();
      // Zero bin size gives no remainder; with zero minimum a bin with no free
      // space is still kept, and a zero-size item fits it.
      configure(24'd0, 24'd0, 10'd0, 1'b0);
      send_item(24'd7);
      send_item(24'd0);
      send_item(24'd5);
      configure(24'hFFFFFF, 24'd1, 10'd0, 1'b0);
      send_item(24'hFFFFFF);
      send_item(24'd1);
      send_item(24'hFFFFFE);
      configure(24'd1, 24'd1, 10'd0, 1'b0);
      send_item(24'd3);
   endtask

   task automatic test_bin_limit();
      // Nothing is kept and no open bin can hold a full-width size, so every
      // item wants a new bin until the counter passes the limit.
      configure(24'd4096, 24'hFFFFFF, next_bin_num[9:0] + 10'd2, 1'b1);
      repeat (4) send_item(24'hFFFFFF);
      send_item(24'd0);                    // refused even though it would fit
      configure(24'd4096, 24'd1, 10'd1023, 1'b1);
      send_item(24'd2000);
      send_item(24'd100);
      configure(24'd4096, 24'd1, 10'd0, 1'b1);   // zero limit turns the check off
      send_item(24'd3000);
      configure(24'd4096, 24'd1, 10'd1, 1'b0);   // mode off ignores the limit
      send_item(24'd3000);
   endtask

   task automatic test_backpressure();
      // The response side stops for a long stretch while items keep coming,
      // so the block fills and holds off the request stream.
      configure(24'd4096, 24'd1, 10'd0, 1'b0);
      @(posedge clock);
      hold_cycles = 200;
      repeat (10) send_item(pick_size(cfg_bin_size, 1'b0));
   endtask

   task automatic random_phase(input logic [23:0] bs, input logic [23:0] mf,
                               input logic [9:0] lim, input logic mode,
                               input int count, input bit fill_heavy,
                               input bit idling);
      int n;
      configure(bs, mf, lim, mode);
      idle_on = idling;
      for (n = 0; n < count; n++) begin
         // Idling comes and goes in stretches within a phase.
         if (idling && n % 40 == 0)
            idle_on = ($urandom_range(0, 3) != 0);
         // Now and then the sender waits for every result before going on.
         if ($urandom_range(0, 79) == 0)
            wait_drained();
         send_item(pick_size(bs, fill_heavy));
      end
   endtask

   task automatic test_random();
      logic [9:0] lim;
      random_phase(24'd4096, 24'd1, 10'd0, 1'b0, 200, 1'b0, 1'b1);
      lim = (next_bin_num + 60 > 1023) ? 10'd1023 : next_bin_num[9:0] + 10'd60;
      random_phase(24'd4096, 24'd1, lim, 1'b1, 150, 1'b0, 1'b1);
      // Tiny bins give many equal leftovers and zero-space entries.
      random_phase(24'($urandom_range(2, 32)), 24'd0, 10'd0, 1'b0, 200, 1'b0, 1'b1);
      random_phase(24'($urandom_range(1, 24'hFFFFFF)), 24'($urandom_range(0, 64)),
                   10'd0, 1'b0, 150, 1'b0, 1'b1);
      // Mostly upper-half sizes fill the table so that leftovers get dropped.
      random_phase(24'd4096, 24'd1, 10'd0, 1'b0, 150, 1'b1, 1'b1);
      // Last part of the run without any idling.
      random_phase(24'd4096, 24'd1, 10'd0, 1'b0, 100, 1'b0, 1'b0);
   endtask

   initial begin
      @(negedge clock);
      while (reset)
         @(negedge clock);
      test_size_extremes();
      test_bin_size_corners();
      test_bin_limit();
      test_backpressure();
      test_random();
      wait_drained();
      // Any stray result still on its way shows up as unexpected here.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
